>>> design/bezier_segment_sampler_unit_defines.svh
// Assertion macros shared by the sampler RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef BEZIER_SEGMENT_SAMPLER_UNIT_DEFINES_SVH
`define BEZIER_SEGMENT_SAMPLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BSS_AST_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BSS_AST_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bss_pkg.sv
// Types, widths and helpers for the cubic Bezier segment sampler.
// Depends on nothing; imported by bezier_segment_sampler_unit.
package bss_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  // x coordinates widen by one bit once the wrap offset is added.
  localparam int X_W           = 33;
  localparam int ALEN_W        = 31;
  // Segment length and divider remainder width.
  localparam int LEN_W         = 34;
  // Width of a rounded weighted sum; independent of the fraction width.
  localparam int R_W           = 38;

  localparam logic [ALEN_W-1:0] ANIM_LENGTH_RST = 31'd1310720;

  // How the curve parameter is formed for one request.
  typedef enum logic [1:0] {
    TS_ZERO = 2'd0,
    TS_ONE  = 2'd1,
    TS_DIV  = 2'd2
  } tsel_t;

  typedef struct packed {
    logic signed [X_W-1:0]     x0;
    logic signed [X_W-1:0]     x1;
    logic signed [X_W-1:0]     x2;
    logic signed [X_W-1:0]     x3;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] y2;
    logic signed [COORD_W-1:0] y3;
  } pts_t;

  typedef struct packed {
    pts_t  pts;
    tsel_t tsel;
    logic  deg;
    logic  wrap;
  } side_t;

  // Clamp a rounded sum to the signed 32-bit range.
  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [R_W-1:0] v);
    if (&v[R_W-1:COORD_W-1] || ~|v[R_W-1:COORD_W-1]) begin
      return v[COORD_W-1:0];
    end else if (v[R_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

>>> design/bezier_segment_sampler_unit.sv
// Top level of the cubic Bezier segment sampler: a deep pipeline with a
// restoring divider, the Bernstein weights and the weighted coordinate sums.
// Depends on bss_pkg and bezier_segment_sampler_unit_defines.svh.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  four control points, sample, wrap flag
//   out_     output     out_valid/ out_stall out_x, out_y, out_degenerate
//   cfg_     input      cfg_valid/ cfg_ready anim_length (ready is always high)
//
// One request enters per clock cycle while in_stall is low; the pipeline has
// FRAC_BITS + 9 register stages, most of them in the restoring divider, which
// resolves one quotient bit of t per stage.
// Reset is synchronous and active low; it clears every stage valid bit and
// loads anim_length with 20.0 s. A stall on the output holds only the stages
// that are full: bubbles further up keep closing, and in_stall rises only when
// every stage holds a request and the output is stalled.
module bezier_segment_sampler_unit
  import bss_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] in_p0_x,
  input  logic signed [COORD_W-1:0] in_p0_y,
  input  logic signed [COORD_W-1:0] in_p1_x,
  input  logic signed [COORD_W-1:0] in_p1_y,
  input  logic signed [COORD_W-1:0] in_p2_x,
  input  logic signed [COORD_W-1:0] in_p2_y,
  input  logic signed [COORD_W-1:0] in_p3_x,
  input  logic signed [COORD_W-1:0] in_p3_y,
  input  logic signed [COORD_W-1:0] in_sample_x,
  input  logic                      in_wrap_segment,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_x,
  output logic signed [COORD_W-1:0] out_y,
  output logic                      out_degenerate,
  // configuration channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ALEN_W-1:0]         cfg_anim_length
);

  // Fixed-point widths. t, u and their squares lie in [0, 1.0].
  localparam int T_W   = FRAC_BITS + 1;
  localparam int W_W   = FRAC_BITS + 2;
  localparam int P_W   = FRAC_BITS + 36;
  localparam int SUM_W = FRAC_BITS + R_W;

  // Stage numbering. Stage 0 forms the wrapped end point, stage 1 the segment
  // length; the divider stages follow, then the polynomial stages.
  localparam int S_T   = FRAC_BITS + 2;
  localparam int S_SQ  = FRAC_BITS + 3;
  localparam int S_W   = FRAC_BITS + 4;
  localparam int S_P   = FRAC_BITS + 5;
  localparam int S_S   = FRAC_BITS + 6;
  localparam int S_R   = FRAC_BITS + 7;
  localparam int S_O   = FRAC_BITS + 8;
  localparam int NSTG  = FRAC_BITS + 9;

  localparam logic [T_W-1:0]   ONE_T  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [SUM_W-1:0] HALF_S = SUM_W'(1) << (FRAC_BITS - 1);

  // Fixed-point product of two values in [0, 1.0], rounded half up.
  function automatic logic [T_W-1:0] fx_mul(input logic [T_W-1:0] a,
                                            input logic [T_W-1:0] b);
    logic [2*T_W:0] p;
    p = (2*T_W+1)'(a) * (2*T_W+1)'(b) + ((2*T_W+1)'(1) << (FRAC_BITS - 1));
    return p[FRAC_BITS +: T_W];
  endfunction

  // Weight times a signed coordinate, exact.
  function automatic logic signed [P_W-1:0] wmul(input logic [W_W-1:0] w,
                                                 input logic signed [X_W-1:0] c);
    logic signed [P_W-1:0] ws;
    logic signed [P_W-1:0] cs;
    ws = signed'(P_W'(w));
    cs = P_W'(c);
    return ws * cs;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration register. Writes arrive only while the pipeline is empty, so
  // the late stages read it directly; the user must keep to this, the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [ALEN_W-1:0] anim_length_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_length_r <= ANIM_LENGTH_RST;
    end else if (cfg_valid) begin
      anim_length_r <= cfg_anim_length;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage valid bits and enables. A stage may load when it, or any stage below
  // it, is empty, or when the output register is draining.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] stg_en;

  for (genvar g = 0; g < NSTG; g++) begin : g_en
    assign stg_en[g] = !out_stall || !(&vld_r[NSTG-1:g]);
  end

  assign in_stall = !stg_en[0];

  always_comb begin
    vld_nxt = vld_r;
    if (stg_en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (stg_en[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: add the wrap offset to the end point and take the differences
  // that the length tests need, all from the request ports.
  // ---------------------------------------------------------------------------
  pts_t                     a_pts_r,  a_pts_nxt;
  logic signed [X_W-1:0]    a_num_r,  a_num_nxt;
  logic signed [X_W-1:0]    a_dx_r,   a_dx_nxt;
  logic [ALEN_W-1:0]        a_aoff_r, a_aoff_nxt;
  logic                     a_wrap_r;

  always_comb begin
    a_aoff_nxt    = in_wrap_segment ? anim_length_r : '0;
    a_pts_nxt.x0  = X_W'(in_p0_x);
    a_pts_nxt.x1  = X_W'(in_p1_x);
    a_pts_nxt.x2  = X_W'(in_p2_x);
    a_pts_nxt.x3  = X_W'(in_p3_x) + signed'(X_W'(a_aoff_nxt));
    a_pts_nxt.y0  = in_p0_y;
    a_pts_nxt.y1  = in_p1_y;
    a_pts_nxt.y2  = in_p2_y;
    a_pts_nxt.y3  = in_p3_y;
    // Sample offset from the start, and from the unwrapped end point; the
    // second one decides t = 1.0 without waiting for the length.
    a_num_nxt     = X_W'(in_sample_x) - X_W'(in_p0_x);
    a_dx_nxt      = X_W'(in_sample_x) - X_W'(in_p3_x);
  end

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      a_pts_r  <= a_pts_nxt;
      a_num_r  <= a_num_nxt;
      a_dx_r   <= a_dx_nxt;
      a_aoff_r <= a_aoff_nxt;
      a_wrap_r <= in_wrap_segment;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 and the divider. Entry 0 of the arrays is stage 1, which forms the
  // length and classifies the request; entry k holds k quotient bits of
  // t = num * 2^FRAC_BITS / len. Under TS_DIV the remainder stays below len.
  // ---------------------------------------------------------------------------
  logic signed [LEN_W:0] len_b;
  logic [LEN_W-1:0]      rem_r  [0:FRAC_BITS];
  logic [LEN_W-1:0]      rem_nxt[0:FRAC_BITS];
  logic [LEN_W-1:0]      len_r  [0:FRAC_BITS];
  logic [LEN_W-1:0]      len_nxt[0:FRAC_BITS];
  logic [FRAC_BITS-1:0]  q_r    [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]  q_nxt  [0:FRAC_BITS];
  side_t                 side_r [0:FRAC_BITS];
  side_t                 side_nxt[0:FRAC_BITS];
  logic [LEN_W:0]        rs     [1:FRAC_BITS];
  logic [FRAC_BITS:1]    qbit;

  always_comb begin
    len_b = (LEN_W+1)'(a_pts_r.x3) - (LEN_W+1)'(a_pts_r.x0);

    side_nxt[0].pts  = a_pts_r;
    side_nxt[0].deg  = (len_b <= 0);
    side_nxt[0].wrap = a_wrap_r;
    if (a_num_r <= 0) begin
      side_nxt[0].tsel = TS_ZERO;
    end else if (a_dx_r >= signed'(X_W'(a_aoff_r))) begin
      side_nxt[0].tsel = TS_ONE;
    end else begin
      side_nxt[0].tsel = TS_DIV;
    end
    rem_nxt[0] = LEN_W'(a_num_r);
    len_nxt[0] = len_b[LEN_W-1:0];
    q_nxt[0]   = '0;

    for (int k = 1; k <= FRAC_BITS; k++) begin
      rs[k]   = {rem_r[k-1], 1'b0};
      qbit[k] = (rs[k] >= {1'b0, len_r[k-1]});
      if (qbit[k]) begin
        rem_nxt[k] = LEN_W'(rs[k] - {1'b0, len_r[k-1]});
      end else begin
        rem_nxt[k] = rs[k][LEN_W-1:0];
      end
      len_nxt[k]  = len_r[k-1];
      q_nxt[k]    = {q_r[k-1][FRAC_BITS-2:0], qbit[k]};
      side_nxt[k] = side_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= FRAC_BITS; k++) begin
      if (stg_en[k+1]) begin
        rem_r[k]  <= rem_nxt[k];
        len_r[k]  <= len_nxt[k];
        q_r[k]    <= q_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Curve parameter t and its complement u.
  // ---------------------------------------------------------------------------
  logic [T_W-1:0] t_r, t_nxt;
  logic [T_W-1:0] u_r, u_nxt;
  side_t          t_side_r;

  always_comb begin
    unique case (side_r[FRAC_BITS].tsel)
      TS_ZERO: t_nxt = '0;
      TS_ONE:  t_nxt = ONE_T;
      TS_DIV:  t_nxt = T_W'(q_r[FRAC_BITS]);
      default: t_nxt = '0;
    endcase
    u_nxt = ONE_T - t_nxt;
  end

  always_ff @(posedge clk) begin
    if (stg_en[S_T]) begin
      t_r      <= t_nxt;
      u_r      <= u_nxt;
      t_side_r <= side_r[FRAC_BITS];
    end
  end

  // Squares.
  logic [T_W-1:0] u2_r, t2_r, sq_t_r, sq_u_r;
  side_t          sq_side_r;

  always_ff @(posedge clk) begin
    if (stg_en[S_SQ]) begin
      u2_r      <= fx_mul(u_r, u_r);
      t2_r      <= fx_mul(t_r, t_r);
      sq_t_r    <= t_r;
      sq_u_r    <= u_r;
      sq_side_r <= t_side_r;
    end
  end

  // Bernstein weights; the middle two carry the factor of three.
  logic [W_W-1:0] w_r   [4];
  logic [W_W-1:0] w_nxt [4];
  logic [T_W-1:0] m1, m2;
  side_t          w_side_r;

  always_comb begin
    m1       = fx_mul(u2_r, sq_t_r);
    m2       = fx_mul(t2_r, sq_u_r);
    w_nxt[0] = W_W'(fx_mul(u2_r, sq_u_r));
    w_nxt[1] = (W_W'(m1) << 1) + W_W'(m1);
    w_nxt[2] = (W_W'(m2) << 1) + W_W'(m2);
    w_nxt[3] = W_W'(fx_mul(t2_r, sq_t_r));
  end

  always_ff @(posedge clk) begin
    if (stg_en[S_W]) begin
      for (int i = 0; i < 4; i++) begin
        w_r[i] <= w_nxt[i];
      end
      w_side_r <= sq_side_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Weighted coordinates: eight exact products, then two levels of adds.
  // ---------------------------------------------------------------------------
  logic signed [P_W-1:0] px_r[4];
  logic signed [P_W-1:0] py_r[4];
  logic                  p_deg_r, p_wrap_r;

  always_ff @(posedge clk) begin
    if (stg_en[S_P]) begin
      px_r[0]  <= wmul(w_r[0], w_side_r.pts.x0);
      px_r[1]  <= wmul(w_r[1], w_side_r.pts.x1);
      px_r[2]  <= wmul(w_r[2], w_side_r.pts.x2);
      px_r[3]  <= wmul(w_r[3], w_side_r.pts.x3);
      py_r[0]  <= wmul(w_r[0], X_W'(w_side_r.pts.y0));
      py_r[1]  <= wmul(w_r[1], X_W'(w_side_r.pts.y1));
      py_r[2]  <= wmul(w_r[2], X_W'(w_side_r.pts.y2));
      py_r[3]  <= wmul(w_r[3], X_W'(w_side_r.pts.y3));
      p_deg_r  <= w_side_r.deg;
      p_wrap_r <= w_side_r.wrap;
    end
  end

  logic signed [SUM_W-1:0] sx01_r, sx23_r, sy01_r, sy23_r;
  logic                    s_deg_r, s_wrap_r;

  always_ff @(posedge clk) begin
    if (stg_en[S_S]) begin
      sx01_r   <= SUM_W'(px_r[0]) + SUM_W'(px_r[1]);
      sx23_r   <= SUM_W'(px_r[2]) + SUM_W'(px_r[3]);
      sy01_r   <= SUM_W'(py_r[0]) + SUM_W'(py_r[1]);
      sy23_r   <= SUM_W'(py_r[2]) + SUM_W'(py_r[3]);
      s_deg_r  <= p_deg_r;
      s_wrap_r <= p_wrap_r;
    end
  end

  // Final sum plus one half, then an arithmetic shift: round half up.
  logic signed [SUM_W-1:0] sumx, sumy;
  logic signed [R_W-1:0]   rx_r, ry_r;
  logic                    r_deg_r, r_wrap_r;

  always_comb begin
    sumx = sx01_r + sx23_r + signed'(HALF_S);
    sumy = sy01_r + sy23_r + signed'(HALF_S);
  end

  always_ff @(posedge clk) begin
    if (stg_en[S_R]) begin
      rx_r     <= sumx[SUM_W-1:FRAC_BITS];
      ry_r     <= sumy[SUM_W-1:FRAC_BITS];
      r_deg_r  <= s_deg_r;
      r_wrap_r <= s_wrap_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: wrap the time once past the animation end, saturate, and
  // force zeros for a segment with no positive length.
  // ---------------------------------------------------------------------------
  logic signed [R_W-1:0]     alen_s;
  logic signed [R_W-1:0]     rx_red;
  logic                      past_end;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt;
  logic signed [COORD_W-1:0] out_y_r, out_y_nxt;
  logic                      out_deg_r;

  always_comb begin
    alen_s   = signed'(R_W'(anim_length_r));
    rx_red   = rx_r - alen_s;
    past_end = r_wrap_r && (rx_r > alen_s);
    if (r_deg_r) begin
      out_x_nxt = '0;
      out_y_nxt = '0;
    end else begin
      out_x_nxt = sat32(past_end ? rx_red : rx_r);
      out_y_nxt = sat32(ry_r);
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[S_O]) begin
      out_x_r   <= out_x_nxt;
      out_y_r   <= out_y_nxt;
      out_deg_r <= r_deg_r;
    end
  end

  assign out_valid      = vld_r[S_O];
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_degenerate = out_deg_r;

  // ---------------------------------------------------------------------------
  // Checks on the pipeline's own logic.
  // ---------------------------------------------------------------------------
`include "bezier_segment_sampler_unit_defines.svh"

  `BSS_AST_IMP(a_deg_zero, clk, rst_n, out_valid && out_degenerate,
               out_x == '0 && out_y == '0, "degenerate result carries nonzero data")
  `BSS_AST_IMP(a_stall_full, clk, rst_n, in_stall, &vld_r,
               "request stalled while a stage is empty")
  `BSS_AST_IMP(a_t_range, clk, rst_n, vld_r[S_T], t_r <= ONE_T, "curve parameter above one")
  `BSS_AST_IMP(a_rem_below, clk, rst_n,
               vld_r[S_T-1] && side_r[FRAC_BITS].tsel == TS_DIV && !side_r[FRAC_BITS].deg,
               rem_r[FRAC_BITS] < len_r[FRAC_BITS], "divider remainder reached the divisor")
  `BSS_AST_NXT(a_out_src, clk, rst_n, !vld_r[S_R] && !(out_valid && out_stall), !out_valid,
               "result appeared without a request behind it")

endmodule
